@@ design/shadow_return_stack_checker_top_macros.svh @@
// assertion macros for the shadow return stack checker
// used by shadow_return_stack_checker_top, expects clk and rst_n in scope
`ifndef SHADOW_RETURN_STACK_CHECKER_TOP_MACROS_SVH
`define SHADOW_RETURN_STACK_CHECKER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SRSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srsc assertion failed");

// next-cycle implication, checked outside reset
`define SRSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srsc assertion failed");

`else

`define SRSC_ASSERT_IMP(lbl, ante, cons)
`define SRSC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ design/srsc_pkg.sv @@
// shared types and constants for the shadow return stack checker
// no dependencies
package srsc_pkg;

    // default geometry
    localparam int THREADS_DEF = 8;
    localparam int DEPTH_DEF   = 64;

    // fixed field widths
    localparam int TID_W       = 3;
    localparam int ADDR_W      = 64;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_OUT_W = 7;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

@@ design/shadow_return_stack_checker_top.sv @@
// shadow return stack checker, top level
// per-thread stacks held in a pointer memory and an entry memory
// depends on srsc_pkg and shadow_return_stack_checker_top_macros.svh
//
// Usage:
//   input channel  in_valid/in_ready carries req_type, thread_id, address;
//   output channel out_valid/out_ready carries status, expected_address,
//   depth_after, one result item per input item, in order.
//   An item passes through a pointer memory read, an entry memory read,
//   then compare and write back. The result becomes valid in the same
//   cycle that in_ready returns high; no new item is accepted while one
//   is in flight, as the read-modify-write goes through the two
//   single-port memories.
//   Thread numbers at or above THREADS fold onto thread_id modulo THREADS.
//   Reset clears one valid flag per thread, so every stack is empty at once;
//   there is no clearing pass and stack entries stay undefined until pushed.
//   When the receiver stalls, the current result waits in the output
//   register, one more item may be worked and parked in a hold register,
//   and in_ready then stays low until the output register drains.
`include "shadow_return_stack_checker_top_macros.svh"

module shadow_return_stack_checker_top
    import srsc_pkg::*;
#(
    parameter int THREADS = THREADS_DEF,
    parameter int DEPTH   = DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   req_type,
    input  logic [TID_W-1:0]       thread_id,
    input  logic [ADDR_W-1:0]      address,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [ADDR_W-1:0]      expected_address,
    output logic [DEPTH_OUT_W-1:0] depth_after
);

    localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int SPW = $clog2(DEPTH + 1);
    localparam int AW  = $clog2(THREADS * DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SP,
        S_ENT,
        S_HOLD
    } state_t;

    // memories
    logic [SPW-1:0]    sp_mem  [0:THREADS-1];
    logic [ADDR_W-1:0] ent_mem [0:THREADS*DEPTH-1];

    state_t            state_reg, state_next;
    logic [THREADS-1:0] sp_vld_reg;
    logic              out_valid_reg;
    status_t           status_reg;
    logic [ADDR_W-1:0] exp_reg;
    logic [DEPTH_OUT_W-1:0] depth_reg;

    logic              req_ret_reg;
    logic [TW-1:0]     tid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              sp_hit_reg;
    logic [SPW-1:0]    sp_rdata_reg;
    logic [SPW-1:0]    sp_cur_reg;
    logic [AW-1:0]     ent_addr_reg;
    logic [ADDR_W-1:0] ent_rdata_reg;

    status_t           res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_exp_reg, res_exp_next;
    logic [SPW-1:0]    res_sp_reg, res_sp_next;

    logic [8:0]        tmod;
    logic [TW-1:0]     tid_in;
    logic              in_acc;
    logic              out_free;
    logic              out_load;
    logic [SPW-1:0]    sp_fix;
    logic [SPW-1:0]    ent_idx;
    logic [AW-1:0]     ent_addr_next;
    logic              ent_rd_en;
    logic              push_wr_en;

    assign in_ready         = (state_reg == S_IDLE);
    assign in_acc           = in_valid && in_ready;
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign expected_address = exp_reg;
    assign depth_after      = depth_reg;
    assign out_free         = !out_valid_reg || out_ready;
    assign out_load         = ((state_reg == S_ENT) || (state_reg == S_HOLD)) && out_free;

    // fold thread number onto the configured thread count
    always_comb
    begin
        tmod = {6'd0, thread_id};
        for (int i = 0; i < 8; i++)
        begin
            if (tmod >= 9'(THREADS))
                tmod = tmod - 9'(THREADS);
        end
        tid_in = tmod[TW-1:0];
    end

    // pointer clamp and entry address, pointer read data in hand
    always_comb
    begin
        logic [SPW-1:0] sp_raw;
        sp_raw = sp_hit_reg ? sp_rdata_reg : '0;
        sp_fix = (sp_raw > SPW'(DEPTH)) ? SPW'(DEPTH) : sp_raw;
        ent_idx = req_ret_reg ? (sp_fix - SPW'(1)) : sp_fix;
        ent_addr_next = AW'(AW'(tid_reg) * AW'(DEPTH)) + AW'(ent_idx);
        ent_rd_en = (state_reg == S_SP) && req_ret_reg && (sp_fix != '0);
    end

    // result of the item, entry read data in hand
    always_comb
    begin
        res_status_next = ST_OK;
        res_exp_next    = '0;
        res_sp_next     = sp_cur_reg;
        push_wr_en      = 1'b0;
        if (!req_ret_reg)
        begin
            if (sp_cur_reg == SPW'(DEPTH))
            begin
                res_status_next = ST_FULL;
            end
            else
            begin
                res_sp_next = sp_cur_reg + SPW'(1);
                push_wr_en  = (state_reg == S_ENT);
            end
        end
        else
        begin
            if (sp_cur_reg == '0)
            begin
                res_status_next = ST_EMPTY;
            end
            else
            begin
                res_exp_next = ent_rdata_reg;
                res_sp_next  = sp_cur_reg - SPW'(1);
                if (ent_rdata_reg != addr_reg)
                    res_status_next = ST_MISMATCH;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_SP;
            S_SP:   state_next = S_ENT;
            S_ENT:  state_next = out_free ? S_IDLE : S_HOLD;
            S_HOLD: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state, valid flags and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            exp_reg       <= '0;
            depth_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready && !out_load)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_ENT:
                begin
                    sp_vld_reg[tid_reg] <= 1'b1;
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_next;
                        exp_reg       <= res_exp_next;
                        depth_reg     <= DEPTH_OUT_W'(res_sp_next);
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        exp_reg       <= res_exp_reg;
                        depth_reg     <= DEPTH_OUT_W'(res_sp_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // item payload and working registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_ret_reg <= req_type;
            tid_reg     <= tid_in;
            addr_reg    <= address;
            sp_hit_reg  <= sp_vld_reg[tid_in];
        end
        if (state_reg == S_SP)
        begin
            sp_cur_reg   <= sp_fix;
            ent_addr_reg <= ent_addr_next;
        end
        if (state_reg == S_ENT)
        begin
            res_status_reg <= res_status_next;
            res_exp_reg    <= res_exp_next;
            res_sp_reg     <= res_sp_next;
        end
    end

    // pointer memory: read at accept, write back at commit
    always_ff @(posedge clk)
    begin
        if (in_acc)
            sp_rdata_reg <= sp_mem[tid_in];
        if (state_reg == S_ENT)
            sp_mem[tid_reg] <= res_sp_next;
    end

    // entry memory: read top on return, write on push
    always_ff @(posedge clk)
    begin
        if (ent_rd_en)
            ent_rdata_reg <= ent_mem[ent_addr_next];
        if (push_wr_en)
            ent_mem[ent_addr_reg] <= addr_reg;
    end

    // checks
    `SRSC_ASSERT_IMP(a_full_depth, out_valid && (status == ST_FULL), depth_after == DEPTH_OUT_W'(DEPTH) && expected_address == '0)
    `SRSC_ASSERT_IMP(a_empty_zero, out_valid && (status == ST_EMPTY), depth_after == '0 && expected_address == '0)
    `SRSC_ASSERT_IMP(a_sp_bound, state_reg == S_ENT, sp_cur_reg <= SPW'(DEPTH))
    `SRSC_ASSERT_NXT(a_accept_seq, in_valid && in_ready, state_reg == S_SP && !in_ready)

endmodule
